// ===== hdl/tcw_pkg.sv =====
// tcw_pkg: shared types, codes and constants of the text console writer
// holds item and result structs, mode and register codes, controller/datapath links
// depends on nothing
package tcw_pkg;

    // screen size defaults
    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    // field widths
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_DW     = CHAR_W + ATTR_W;
    localparam int CURSOR_W    = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // character codes
    localparam logic [CHAR_W-1:0] NL_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] MARK_CODE  = 8'h45;

    // attribute reset values
    localparam logic [ATTR_W-1:0] RESET_ATTR       = 8'h0F;
    localparam logic [ATTR_W-1:0] RESET_ERROR_ATTR = 8'hF4;

    // operation codes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_ATTR   = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attr;
        logic              use_cursor;
        logic [6:0]        col;
        logic [5:0]        row;
    } in_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic                coord_error;
        logic [CHAR_W-1:0]   read_char;
        logic [ATTR_W-1:0]   read_attr;
    } out_t;

    // attribute source of a blanking sweep
    typedef enum logic [1:0] {
        FILL_RESET,
        FILL_CLEAR,
        FILL_SCROLL
    } fill_kind_t;

    // start address of a sweep
    typedef enum logic [1:0] {
        SWEEP_FIRST,
        SWEEP_COPY,
        SWEEP_LAST_ROW
    } sweep_sel_t;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       read_cell;
        logic       cp_read;
        logic       fill;
        logic       sweep_load;
        sweep_sel_t sweep_sel;
        fill_kind_t fill_kind;
        logic       res_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       wrap;
        logic       outside;
        logic       sweep_end;
    } status_t;

endpackage

// ===== hdl/text_console_writer_core.sv =====
// text_console_writer_core: text console engine, COLUMNS x ROWS cells with a cursor
// every item ends in a result beat; an on-screen read waits on the buffer read, clear blanks every cell,
// scroll copies rows up and blanks the last row; the result beat is in the cycle in which busy falls
// throughput: a new item may be taken in the result beat's cycle; scroll and clear sweep one cell per cycle
// reset: cursor homed, registers at defaults, then a clearing pass over all CELLS cells
// with busy high; results cannot be stalled by the receiver
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tcw_pkg::in_t                    item,
    output logic                            done,
    output tcw_pkg::out_t                   result,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;

    // sequencer
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // buffer, cursor and result
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== hdl/tcw_ctrl.sv =====
// tcw_ctrl: sequencer of the text console writer
// steps the datapath through write, read, scroll, clear and the reset clearing pass
// depends on tcw_pkg
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL
    } state_t;

    state_t               state_reg, state_next;
    tcw_pkg::fill_kind_t  fill_kind_reg, fill_kind_next;

    // next state and command decode
    always_comb
    begin
        state_next          = state_reg;
        fill_kind_next      = fill_kind_reg;
        cmd                 = '0;
        cmd.sweep_sel       = tcw_pkg::SWEEP_FIRST;
        cmd.fill_kind       = fill_kind_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill = 1'b1;
                if (status.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (status.op)
                    tcw_pkg::MODE_WRITE:
                    begin
                        if (status.wrap)
                        begin
                            cmd.sweep_load = 1'b1;
                            cmd.sweep_sel  = tcw_pkg::SWEEP_COPY;
                            fill_kind_next = tcw_pkg::FILL_SCROLL;
                            state_next     = ST_SCROLL;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    tcw_pkg::MODE_CLEAR:
                    begin
                        cmd.sweep_load = 1'b1;
                        cmd.sweep_sel  = tcw_pkg::SWEEP_FIRST;
                        fill_kind_next = tcw_pkg::FILL_CLEAR;
                        state_next     = ST_FILL;
                    end
                    tcw_pkg::MODE_READ:
                    begin
                        if (status.outside)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cmd.read_cell = 1'b1;
                            state_next    = ST_RWAIT;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_RWAIT:
            begin
                cmd.res_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCROLL:
            begin
                cmd.cp_read = 1'b1;
                if (status.sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.sweep_load = 1'b1;
                cmd.sweep_sel  = tcw_pkg::SWEEP_LAST_ROW;
                state_next     = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.sweep_end)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and fill source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            fill_kind_reg <= tcw_pkg::FILL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_kind_reg <= fill_kind_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/tcw_datapath.sv =====
// tcw_datapath: cell buffer, cursor, registers and result of the text console writer
// executes the commands of tcw_ctrl one step per cycle
// depends on tcw_pkg
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcw_pkg::in_t                    item,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  tcw_pkg::cmd_t                   cmd,
    output tcw_pkg::status_t                status,
    output logic                            done,
    output tcw_pkg::out_t                   result
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int DW     = tcw_pkg::CELL_DW;
    localparam int AW     = tcw_pkg::ATTR_W;
    localparam int CW     = tcw_pkg::CHAR_W;
    localparam int OW     = tcw_pkg::CURSOR_W;

    localparam logic [7:0]        COLS_LIM   = 8'(COLUMNS);
    localparam logic [6:0]        ROWS_LIM   = 7'(ROWS);
    localparam logic [COL_W:0]    COL_END    = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_END    = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] COLS_C     = CELL_W'(COLUMNS);
    localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] LAST_ROW_0 = CELL_W'(CELLS - COLUMNS);

    // cell buffer: {attribute, character}
    logic [DW-1:0]     mem [CELLS];
    logic [DW-1:0]     rdata_reg;

    tcw_pkg::in_t      item_reg;
    logic [AW-1:0]     default_attr_reg;
    logic [AW-1:0]     error_attr_reg;
    logic [ROW_W-1:0]  crow_reg, crow_next;
    logic [COL_W-1:0]  ccol_reg, ccol_next;
    logic [CELL_W-1:0] sweep_reg, sweep_next;
    logic              wpend_reg;
    logic [CELL_W-1:0] waddr_reg;
    logic              done_reg;
    tcw_pkg::out_t     res_reg, res_next;

    logic              outside, is_write, is_nl, err_write, line_end, row_wrap;
    logic [AW-1:0]     eff_attr, fill_attr;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [CELL_W-1:0] tgt_addr, item_addr, op_addr, cur_cell;
    logic              op_we;
    logic [DW-1:0]     op_data;
    logic [CELL_W+OW-1:0] cur_ext;

    // decode of the held item and cursor update
    always_comb
    begin
        outside   = ({1'b0, item_reg.col} >= COLS_LIM) || ({1'b0, item_reg.row} >= ROWS_LIM);
        is_write  = (item_reg.mode == tcw_pkg::MODE_WRITE);
        is_nl     = (item_reg.char_code == tcw_pkg::NL_CODE);
        err_write = is_write && !item_reg.use_cursor && outside;
        eff_attr  = (item_reg.attr == '0) ? default_attr_reg : item_reg.attr;

        if (item_reg.use_cursor)
        begin
            tgt_row = crow_reg;
            tgt_col = ccol_reg;
        end
        else
        begin
            tgt_row = item_reg.row[ROW_W-1:0];
            tgt_col = item_reg.col[COL_W-1:0];
        end

        tgt_addr  = CELL_W'(tgt_row) * COLS_C + CELL_W'(tgt_col);
        item_addr = CELL_W'(item_reg.row[ROW_W-1:0]) * COLS_C
                    + CELL_W'(item_reg.col[COL_W-1:0]);

        col_inc  = {1'b0, tgt_col} + 1'b1;
        row_inc  = {1'b0, tgt_row} + 1'b1;
        line_end = is_nl || (col_inc == COL_END);
        row_wrap = line_end && (row_inc == ROW_END);

        crow_next = crow_reg;
        ccol_next = ccol_reg;
        if (cmd.exec)
        begin
            if (is_write && !err_write)
            begin
                if (row_wrap)
                begin
                    crow_next = ROW_LAST;
                    ccol_next = '0;
                end
                else if (line_end)
                begin
                    crow_next = row_inc[ROW_W-1:0];
                    ccol_next = '0;
                end
                else
                begin
                    crow_next = tgt_row;
                    ccol_next = col_inc[COL_W-1:0];
                end
            end
            else if (item_reg.mode == tcw_pkg::MODE_CLEAR)
            begin
                crow_next = '0;
                ccol_next = '0;
            end
        end

        // single cell write of a character or the error mark
        op_we   = is_write && (err_write || !is_nl);
        op_addr = err_write ? LAST_CELL : tgt_addr;
        op_data = err_write ? {error_attr_reg, tcw_pkg::MARK_CODE}
                            : {eff_attr, item_reg.char_code};

        case (cmd.fill_kind)
            tcw_pkg::FILL_RESET:  fill_attr = tcw_pkg::RESET_ATTR;
            tcw_pkg::FILL_CLEAR:  fill_attr = default_attr_reg;
            tcw_pkg::FILL_SCROLL: fill_attr = eff_attr;
            default:              fill_attr = tcw_pkg::RESET_ATTR;
        endcase

        case (cmd.sweep_sel)
            tcw_pkg::SWEEP_FIRST:    sweep_next = '0;
            tcw_pkg::SWEEP_COPY:     sweep_next = COLS_C;
            tcw_pkg::SWEEP_LAST_ROW: sweep_next = LAST_ROW_0;
            default:                 sweep_next = '0;
        endcase
        if (!cmd.sweep_load)
        begin
            sweep_next = (cmd.cp_read || cmd.fill) ? sweep_reg + 1'b1 : sweep_reg;
        end

        // result beat
        cur_cell              = CELL_W'(crow_next) * COLS_C + CELL_W'(ccol_next);
        cur_ext               = {OW'(0), cur_cell};
        res_next.cursor_cell  = cur_ext[OW-1:0];
        res_next.coord_error  = err_write || ((item_reg.mode == tcw_pkg::MODE_READ) && outside);
        if ((item_reg.mode == tcw_pkg::MODE_READ) && !outside)
        begin
            res_next.read_char = rdata_reg[CW-1:0];
            res_next.read_attr = rdata_reg[DW-1:CW];
        end
        else
        begin
            res_next.read_char = '0;
            res_next.read_attr = '0;
        end
    end

    // status to the sequencer
    assign status.op        = item_reg.mode;
    assign status.wrap      = is_write && !err_write && row_wrap;
    assign status.outside   = outside;
    assign status.sweep_end = (sweep_reg == LAST_CELL);

    // cell buffer ports: copy write, then fill, then single cell write
    always_ff @(posedge clk)
    begin
        if (wpend_reg)
        begin
            mem[waddr_reg] <= rdata_reg;
        end
        else if (cmd.fill)
        begin
            mem[sweep_reg] <= {fill_attr, tcw_pkg::BLANK_CODE};
        end
        else if (cmd.exec && op_we)
        begin
            mem[op_addr] <= op_data;
        end

        if (cmd.cp_read)
        begin
            rdata_reg <= mem[sweep_reg];
        end
        else if (cmd.read_cell)
        begin
            rdata_reg <= mem[item_addr];
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.cp_read)
        begin
            waddr_reg <= sweep_reg - COLS_C;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    // control state, cursor and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= tcw_pkg::RESET_ATTR;
            error_attr_reg   <= tcw_pkg::RESET_ERROR_ATTR;
            crow_reg         <= '0;
            ccol_reg         <= '0;
            sweep_reg        <= '0;
            wpend_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcw_pkg::CFG_DEFAULT_ATTR: default_attr_reg <= cfg_data[AW-1:0];
                    tcw_pkg::CFG_ERROR_ATTR:   error_attr_reg   <= cfg_data[AW-1:0];
                    default:                   ;
                endcase
            end
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            sweep_reg <= sweep_next;
            wpend_reg <= cmd.cp_read;
            done_reg  <= cmd.res_load;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
